>>> design/rhp_pkg.sv
package rhp_pkg;

    localparam logic [1:0]  RTP_VERSION = 2'd2;
    localparam logic [18:0] FIXED_HDR   = 19'd12;
    localparam logic [18:0] WORD_BYTES  = 19'd4;
    localparam logic [7:0]  MIN_PAD     = 8'd1;

    // Header state as it stands once the current byte has been taken in.
    typedef struct packed {
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] sequence_num;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [15:0] ext_words;
        logic [16:0] pkt_size;
        logic [7:0]  last_data;
    } hdr_t;

    typedef struct packed {
        logic        parse_ok;
        logic [15:0] payload_offset;
        logic [15:0] payload_size;
    } res_t;

endpackage

>>> design/rtp_header_parser.sv
// Channel  Handshake           Payload
// input    in_valid/in_ready   data_byte, last_byte
// output   out_valid/out_ready parse_ok, payload_offset, payload_size, marker, payload_type,
//                              sequence_res, timestamp, ssrc, csrc_count, has_extension,
//                              has_padding
//
// One byte is accepted per cycle while no last byte is held back; a result appears
// when the last byte moves from the input register into the result register.
// Reset is asynchronous and clears the byte counter and the captured header.
// A waiting result stalls only the last byte of the next packet; other bytes keep
// flowing because they produce no result.
module rtp_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        parse_ok,
    output logic [15:0] payload_offset,
    output logic [15:0] payload_size,
    output logic        marker,
    output logic [6:0]  payload_type,
    output logic [15:0] sequence_res,
    output logic [31:0] timestamp,
    output logic [31:0] ssrc,
    output logic [3:0]  csrc_count,
    output logic        has_extension,
    output logic        has_padding
);

    logic          st_valid;
    logic [7:0]    st_data;
    logic          st_last;
    logic          advance;
    rhp_pkg::hdr_t hdr;
    rhp_pkg::res_t res;

    logic          out_valid_reg;
    logic          out_valid_next;
    rhp_pkg::res_t res_reg;
    rhp_pkg::hdr_t hdr_reg;

    assign advance = st_valid && (!st_last || !out_valid_reg || out_ready);

    rhp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .advance   (advance),
        .st_valid  (st_valid),
        .st_data   (st_data),
        .st_last   (st_last)
    );

    rhp_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .st_data (st_data),
        .st_last (st_last),
        .hdr     (hdr)
    );

    rhp_check u_check (
        .hdr (hdr),
        .res (res)
    );

    assign out_valid_next = (advance && st_last) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && st_last)
        begin
            res_reg <= res;
            hdr_reg <= hdr;
        end
    end

    assign out_valid      = out_valid_reg;
    assign parse_ok       = res_reg.parse_ok;
    assign payload_offset = res_reg.payload_offset;
    assign payload_size   = res_reg.payload_size;
    assign marker         = hdr_reg.second_byte[7];
    assign payload_type   = hdr_reg.second_byte[6:0];
    assign sequence_res   = hdr_reg.sequence_num;
    assign timestamp      = hdr_reg.timestamp;
    assign ssrc           = hdr_reg.ssrc;
    assign csrc_count     = hdr_reg.first_byte[3:0];
    assign has_extension  = hdr_reg.first_byte[4];
    assign has_padding    = hdr_reg.first_byte[5];

endmodule

>>> design/rhp_in_stage.sv
module rhp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       advance,
    output logic       st_valid,
    output logic [7:0] st_data,
    output logic       st_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    // The stage refills in the same cycle that its item moves on.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign st_valid = valid_reg;
    assign st_data  = data_reg;
    assign st_last  = last_reg;

endmodule

>>> design/rhp_capture.sv
module rhp_capture (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [7:0]   st_data,
    input  logic         st_last,
    output rhp_pkg::hdr_t hdr
);

    logic [15:0] byte_count_reg;
    logic [15:0] byte_count_next;
    logic        oversize_reg;
    logic        oversize_next;
    logic [7:0]  first_reg;
    logic [7:0]  first_next;
    logic [7:0]  second_reg;
    logic [7:0]  second_next;
    logic [15:0] seq_reg;
    logic [15:0] seq_next;
    logic [31:0] ts_reg;
    logic [31:0] ts_next;
    logic [31:0] ssrc_reg;
    logic [31:0] ssrc_next;
    logic [15:0] ext_reg;
    logic [15:0] ext_next;
    logic [15:0] ext_pos;

    // The extension length sits two bytes into the extension header.
    assign ext_pos = 16'd14 + {10'd0, first_reg[3:0], 2'b00};

    always_comb
    begin
        byte_count_next = byte_count_reg;
        oversize_next   = oversize_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        seq_next        = seq_reg;
        ts_next         = ts_reg;
        ssrc_next       = ssrc_reg;
        ext_next        = ext_reg;
        if (!oversize_reg)
        begin
            if (byte_count_reg == 16'd0)
            begin
                first_next = st_data;
            end
            else if (byte_count_reg == 16'd1)
            begin
                second_next = st_data;
            end
            else if (byte_count_reg < 16'd4)
            begin
                seq_next = {seq_reg[7:0], st_data};
            end
            else if (byte_count_reg < 16'd8)
            begin
                ts_next = {ts_reg[23:0], st_data};
            end
            else if (byte_count_reg < 16'd12)
            begin
                ssrc_next = {ssrc_reg[23:0], st_data};
            end
            else if (byte_count_reg == ext_pos || byte_count_reg == ext_pos + 16'd1)
            begin
                ext_next = {ext_reg[7:0], st_data};
            end
            if (byte_count_reg == 16'hFFFF)
            begin
                oversize_next = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_reg + 16'd1;
            end
        end
    end

    // The counter saturates, so count plus one also covers the oversize case.
    assign hdr.first_byte   = first_next;
    assign hdr.second_byte  = second_next;
    assign hdr.sequence_num = seq_next;
    assign hdr.timestamp    = ts_next;
    assign hdr.ssrc         = ssrc_next;
    assign hdr.ext_words    = ext_next;
    assign hdr.pkt_size     = {1'b0, byte_count_reg} + 17'd1;
    assign hdr.last_data    = st_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            oversize_reg   <= 1'b0;
            first_reg      <= '0;
            second_reg     <= '0;
            seq_reg        <= '0;
            ts_reg         <= '0;
            ssrc_reg       <= '0;
            ext_reg        <= '0;
        end
        else if (advance)
        begin
            if (st_last)
            begin
                byte_count_reg <= '0;
                oversize_reg   <= 1'b0;
                first_reg      <= '0;
                second_reg     <= '0;
                seq_reg        <= '0;
                ts_reg         <= '0;
                ssrc_reg       <= '0;
                ext_reg        <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                oversize_reg   <= oversize_next;
                first_reg      <= first_next;
                second_reg     <= second_next;
                seq_reg        <= seq_next;
                ts_reg         <= ts_next;
                ssrc_reg       <= ssrc_next;
                ext_reg        <= ext_next;
            end
        end
    end

endmodule

>>> design/rhp_check.sv
module rhp_check (
    input  rhp_pkg::hdr_t hdr,
    output rhp_pkg::res_t res
);

    logic [18:0] size_w;
    logic [18:0] need_csrc;
    logic [18:0] need_ext;
    logic [18:0] need_tot;
    logic [7:0]  pad;
    logic [18:0] pad_w;
    logic [18:0] psize_w;
    logic        has_pad;
    logic        ok;

    assign size_w    = {2'b00, hdr.pkt_size};
    assign need_csrc = rhp_pkg::FIXED_HDR + {13'd0, hdr.first_byte[3:0], 2'b00};
    assign need_ext  = rhp_pkg::WORD_BYTES + {1'b0, hdr.ext_words, 2'b00};
    assign need_tot  = need_csrc + (hdr.first_byte[4] ? need_ext : 19'd0);
    assign has_pad   = hdr.first_byte[5];

    // A padding count of zero is treated as one byte.
    assign pad     = (hdr.last_data < rhp_pkg::MIN_PAD) ? rhp_pkg::MIN_PAD : hdr.last_data;
    assign pad_w   = has_pad ? {11'd0, pad} : 19'd0;
    assign psize_w = size_w - need_tot - pad_w;

    assign ok = !hdr.pkt_size[16]
             && (hdr.first_byte[7:6] == rhp_pkg::RTP_VERSION)
             && (size_w >= need_tot)
             && (size_w >= need_tot + pad_w);

    assign res.parse_ok       = ok;
    assign res.payload_size   = ok ? psize_w[15:0] : 16'd0;
    assign res.payload_offset = (ok && (psize_w[15:0] != 16'd0)) ? need_tot[15:0] : 16'd0;

endmodule

>>> design/rhp_checker.sv
module rhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        parse_ok,
    input logic [15:0] payload_offset,
    input logic [15:0] payload_size
);

    // A held result must not change while the consumer stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_offset)
            && $stable(payload_size) && $stable(parse_ok))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> payload_offset == 16'd0 && payload_size == 16'd0)
        else $error("failed parse reports nonzero offset or size");

    a_offset_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok && payload_size != 16'd0 |-> payload_offset >= 16'd12)
        else $error("payload offset inside fixed header");

    a_empty_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok && payload_size == 16'd0 |-> payload_offset == 16'd0)
        else $error("empty payload with nonzero offset");

    a_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok |-> ({1'b0, payload_offset} + {1'b0, payload_size}) <= 17'hFFFF)
        else $error("payload extends past packet size limit");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .parse_ok       (parse_ok),
    .payload_offset (payload_offset),
    .payload_size   (payload_size)
);
